// ----- rtl/core/rsi_pkg.sv -----
package rsi_pkg;

  // default geometry
  localparam int DEF_PRICE_WIDTH   = 32;
  localparam int DEF_AVG_FRAC_BITS = 16;

  // average and divider widths
  localparam int AVG_W = 64;
  localparam int NUM_W = 2 * AVG_W;

  // period register and sample counter
  localparam int PERIOD_W = 8;
  localparam int COUNT_W  = PERIOD_W + 1;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd14;

  // result scaling, 100 * 256
  localparam int RSI_W = 15;
  localparam logic [RSI_W-1:0] RSI_SCALE = 15'd25600;

  // product widths
  localparam int SMOOTH_PROD_W = AVG_W + PERIOD_W;
  localparam int RSI_PROD_W    = AVG_W + RSI_W;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic accumulate;
    logic mul_smooth;
    logic warm_go;
    logic smooth_go;
    logic avg_store;
    logic rsi_special;
    logic rsi_mul;
    logic rsi_go;
    logic rsi_store;
    logic out_load;
  } rsi_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic first;
    logic off;
    logic warm_more;
    logic warm_last;
    logic div_busy;
    logic loss_zero;
  } rsi_sts_t;

endpackage

// ----- rtl/core/rsi_if.sv -----
// price stream
interface rsi_in_if #(
  parameter int PRICE_WIDTH = rsi_pkg::DEF_PRICE_WIDTH
);
  logic                   valid;
  logic                   ready;
  logic [PRICE_WIDTH-1:0] price;

  modport source (output valid, output price, input ready);
  modport sink   (input valid, input price, output ready);
endinterface

// result stream
interface rsi_out_if;
  logic                       valid;
  logic                       ready;
  logic [rsi_pkg::RSI_W-1:0]  rsi_value;
  logic                       rsi_valid;

  modport source (output valid, output rsi_value, output rsi_valid, input ready);
  modport sink   (input valid, input rsi_value, input rsi_valid, output ready);
endinterface

// period register write
interface rsi_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [rsi_pkg::PERIOD_W-1:0] period;

  modport source (output valid, output period, input ready);
  modport sink   (input valid, input period, output ready);
endinterface

// ----- rtl/core/relative_strength_index.sv -----
// Wilder relative strength index. Each price transaction on in_chan yields exactly one
// result transaction on out_chan: rsi_value is RSI * 256 (0 to 25600) and rsi_valid marks
// it defined, from the sample whose index equals period onward; during warm-up both are
// zero. The block works on one transaction at a time. A warm-up sample uses neither divider;
// a sample that produces a valid result waits on the two 64-step restoring dividers: one
// pass for the gain and loss averages (run side by side), then one pass for the ratio on
// the gain divider. The ratio pass is skipped when the loss average is zero. The next price
// is accepted as soon as the result sits in the output register, even if the sink has not
// taken it yet. The period register is written through cfg_chan, which is always
// ready, and must only be written while no transaction is in flight.
module relative_strength_index #(
  parameter int PRICE_WIDTH   = rsi_pkg::DEF_PRICE_WIDTH,
  parameter int AVG_FRAC_BITS = rsi_pkg::DEF_AVG_FRAC_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  rsi_in_if.sink     in_chan,
  rsi_out_if.source  out_chan,
  rsi_cfg_if.sink    cfg_chan
);

  rsi_pkg::rsi_cmd_t cmd;
  rsi_pkg::rsi_sts_t sts;

  // period writes are taken at any time
  assign cfg_chan.ready = 1'b1;

  rsi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rsi_dp #(
    .PRICE_WIDTH   (PRICE_WIDTH),
    .AVG_FRAC_BITS (AVG_FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_price   (in_chan.price),
    .cfg_we     (cfg_chan.valid),
    .cfg_period (cfg_chan.period),
    .out_value  (out_chan.rsi_value),
    .out_flag   (out_chan.rsi_valid)
  );

endmodule

// ----- rtl/core/rsi_div.sv -----
module rsi_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [rsi_pkg::NUM_W-1:0] num,
  input  logic [rsi_pkg::AVG_W-1:0] den,
  output logic                      busy,
  output logic [rsi_pkg::AVG_W-1:0] quo
);

  localparam int W     = rsi_pkg::AVG_W;
  localparam int STEPS = rsi_pkg::AVG_W;
  localparam int CNT_W = $clog2(STEPS);

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [W-1:0]     rem_r;
  logic [W-1:0]     q_r;
  logic [W-1:0]     den_r;

  logic [W:0]   rem_ext;
  logic [W:0]   diff;
  logic         ge;
  logic [W-1:0] rem_nxt;
  logic [W-1:0] q_nxt;
  logic         sat;

  // quotient overflows 64 bits or divisor is zero
  assign sat = (den == '0) || (num[2*W-1:W] >= den);

  // one restoring step per cycle
  assign rem_ext = {rem_r, q_r[W-1]};
  assign diff    = rem_ext - {1'b0, den_r};
  assign ge      = rem_ext >= {1'b0, den_r};
  assign rem_nxt = ge ? diff[W-1:0] : rem_ext[W-1:0];
  assign q_nxt   = {q_r[W-2:0], ge};

  // step control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= !sat;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(STEPS - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num[2*W-1:W];
      q_r   <= sat ? '1 : num[W-1:0];
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  assign busy = busy_r;
  assign quo  = q_r;

endmodule

// ----- rtl/core/rsi_dp.sv -----
module rsi_dp #(
  parameter int PRICE_WIDTH   = rsi_pkg::DEF_PRICE_WIDTH,
  parameter int AVG_FRAC_BITS = rsi_pkg::DEF_AVG_FRAC_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rsi_pkg::rsi_cmd_t            cmd,
  output rsi_pkg::rsi_sts_t            sts,
  input  logic [PRICE_WIDTH-1:0]       in_price,
  input  logic                         cfg_we,
  input  logic [rsi_pkg::PERIOD_W-1:0] cfg_period,
  output logic [rsi_pkg::RSI_W-1:0]    out_value,
  output logic                         out_flag
);

  localparam int AW  = rsi_pkg::AVG_W;
  localparam int NW  = rsi_pkg::NUM_W;
  localparam int PW  = rsi_pkg::PERIOD_W;
  localparam int CW  = rsi_pkg::COUNT_W;
  localparam int RW  = rsi_pkg::RSI_W;
  localparam int SPW = rsi_pkg::SMOOTH_PROD_W;
  localparam int RPW = rsi_pkg::RSI_PROD_W;

  // state
  logic [PW-1:0]          period_r;
  logic [CW-1:0]          count_r;
  logic [PRICE_WIDTH-1:0] last_r;
  logic [AW-1:0]          gain_avg_r;
  logic [AW-1:0]          loss_avg_r;

  // per-transaction working registers
  logic [PRICE_WIDTH-1:0] gain_r;
  logic [PRICE_WIDTH-1:0] loss_r;
  logic [SPW-1:0]         sm_g_r;
  logic [SPW-1:0]         sm_l_r;
  logic [RPW-1:0]         rsi_prod_r;
  logic [RW-1:0]          res_value_r;
  logic                   res_flag_r;
  logic [RW-1:0]          out_value_r;
  logic                   out_flag_r;

  logic [CW-1:0]          period_ext;
  logic [PRICE_WIDTH-1:0] gain_in;
  logic [PRICE_WIDTH-1:0] loss_in;
  logic [PW-1:0]          period_m1;
  logic [AW-1:0]          warm_sum_g;
  logic [AW-1:0]          warm_sum_l;
  logic [NW-1:0]          warm_num_g;
  logic [NW-1:0]          warm_num_l;
  logic [NW-1:0]          smooth_num_g;
  logic [NW-1:0]          smooth_num_l;
  logic [AW:0]            total;
  logic [AW-1:0]          rsi_den;
  logic [AW-1:0]          period_den;

  logic          g_start;
  logic          l_start;
  logic [NW-1:0] g_num;
  logic [NW-1:0] l_num;
  logic [AW-1:0] g_den;
  logic          g_busy;
  logic          l_busy;
  logic [AW-1:0] g_quo;
  logic [AW-1:0] l_quo;

  // status toward the controller
  assign period_ext    = {1'b0, period_r};
  assign sts.first     = count_r == '0;
  assign sts.off       = period_r == '0;
  assign sts.warm_more = count_r < period_ext;
  assign sts.warm_last = count_r == period_ext;
  assign sts.div_busy  = g_busy | l_busy;
  assign sts.loss_zero = loss_avg_r == '0;

  // gain and loss against the last price
  assign gain_in = (in_price > last_r) ? in_price - last_r : '0;
  assign loss_in = (last_r > in_price) ? last_r - in_price : '0;

  // numerators for the end of warm-up
  assign warm_sum_g = gain_avg_r + AW'(gain_r);
  assign warm_sum_l = loss_avg_r + AW'(loss_r);
  assign warm_num_g = NW'(warm_sum_g) << AVG_FRAC_BITS;
  assign warm_num_l = NW'(warm_sum_l) << AVG_FRAC_BITS;

  // numerators for wilder smoothing
  assign period_m1    = period_r - PW'(1);
  assign smooth_num_g = NW'(sm_g_r) + (NW'(gain_r) << AVG_FRAC_BITS);
  assign smooth_num_l = NW'(sm_l_r) + (NW'(loss_r) << AVG_FRAC_BITS);

  // ratio divisor, saturating sum of both averages
  assign total   = {1'b0, gain_avg_r} + {1'b0, loss_avg_r};
  assign rsi_den = total[AW] ? '1 : total[AW-1:0];

  // divider operand selection
  assign period_den = AW'(period_r);
  assign g_start    = cmd.warm_go | cmd.smooth_go | cmd.rsi_go;
  assign l_start    = cmd.warm_go | cmd.smooth_go;
  assign g_num      = cmd.rsi_go ? NW'(rsi_prod_r) :
                      (cmd.smooth_go ? smooth_num_g : warm_num_g);
  assign g_den      = cmd.rsi_go ? rsi_den : period_den;
  assign l_num      = cmd.smooth_go ? smooth_num_l : warm_num_l;

  rsi_div u_div_gain (
    .clk   (clk),
    .rst_n (rst_n),
    .start (g_start),
    .num   (g_num),
    .den   (g_den),
    .busy  (g_busy),
    .quo   (g_quo)
  );

  rsi_div u_div_loss (
    .clk   (clk),
    .rst_n (rst_n),
    .start (l_start),
    .num   (l_num),
    .den   (period_den),
    .busy  (l_busy),
    .quo   (l_quo)
  );

  // period register, count, last price and averages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r   <= rsi_pkg::PERIOD_RESET;
      count_r    <= '0;
      last_r     <= '0;
      gain_avg_r <= '0;
      loss_avg_r <= '0;
    end else begin
      if (cfg_we) begin
        period_r <= cfg_period;
      end
      if (cmd.capture) begin
        last_r <= in_price;
        if (sts.first) begin
          count_r <= CW'(1);
        end else if (!sts.off && count_r <= period_ext) begin
          count_r <= count_r + CW'(1);
        end
      end
      if (cmd.accumulate) begin
        gain_avg_r <= gain_avg_r + AW'(gain_r);
        loss_avg_r <= loss_avg_r + AW'(loss_r);
      end
      if (cmd.avg_store) begin
        gain_avg_r <= g_quo;
        loss_avg_r <= l_quo;
      end
    end
  end

  // working registers and result staging
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      gain_r      <= gain_in;
      loss_r      <= loss_in;
      res_value_r <= '0;
      res_flag_r  <= 1'b0;
    end
    if (cmd.mul_smooth) begin
      sm_g_r <= gain_avg_r * period_m1;
      sm_l_r <= loss_avg_r * period_m1;
    end
    if (cmd.rsi_mul) begin
      rsi_prod_r <= gain_avg_r * rsi_pkg::RSI_SCALE;
    end
    if (cmd.rsi_special) begin
      res_flag_r  <= 1'b1;
      res_value_r <= (gain_avg_r == '0) ? '0 : rsi_pkg::RSI_SCALE;
    end
    if (cmd.rsi_store) begin
      res_flag_r  <= 1'b1;
      res_value_r <= (g_quo > AW'(rsi_pkg::RSI_SCALE)) ? rsi_pkg::RSI_SCALE : g_quo[RW-1:0];
    end
    if (cmd.out_load) begin
      out_value_r <= res_value_r;
      out_flag_r  <= res_flag_r;
    end
  end

  assign out_value = out_value_r;
  assign out_flag  = out_flag_r;

endmodule

// ----- rtl/core/rsi_ctrl.sv -----
module rsi_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  rsi_pkg::rsi_sts_t sts,
  output rsi_pkg::rsi_cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACC,
    ST_MUL,
    ST_WARM_GO,
    ST_SMOOTH_GO,
    ST_AVG_WAIT,
    ST_RSI_SEL,
    ST_RSI_GO,
    ST_RSI_WAIT,
    ST_OUT
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   accept;
  logic   out_free;

  assign in_ready = state_r == ST_IDLE;
  assign accept   = in_valid & in_ready;
  assign out_free = !out_valid_r | out_ready;

  // command decode and next state
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        cmd.capture = accept;
        if (accept) begin
          priority if (sts.first || sts.off) begin
            state_nxt = ST_OUT;
          end else if (sts.warm_more) begin
            state_nxt = ST_ACC;
          end else if (sts.warm_last) begin
            state_nxt = ST_WARM_GO;
          end else begin
            state_nxt = ST_MUL;
          end
        end
      end
      ST_ACC: begin
        cmd.accumulate = 1'b1;
        state_nxt      = ST_OUT;
      end
      ST_MUL: begin
        cmd.mul_smooth = 1'b1;
        state_nxt      = ST_SMOOTH_GO;
      end
      ST_WARM_GO: begin
        cmd.warm_go = 1'b1;
        state_nxt   = ST_AVG_WAIT;
      end
      ST_SMOOTH_GO: begin
        cmd.smooth_go = 1'b1;
        state_nxt     = ST_AVG_WAIT;
      end
      ST_AVG_WAIT: begin
        if (!sts.div_busy) begin
          cmd.avg_store = 1'b1;
          state_nxt     = ST_RSI_SEL;
        end
      end
      ST_RSI_SEL: begin
        if (sts.loss_zero) begin
          cmd.rsi_special = 1'b1;
          state_nxt       = ST_OUT;
        end else begin
          cmd.rsi_mul = 1'b1;
          state_nxt   = ST_RSI_GO;
        end
      end
      ST_RSI_GO: begin
        cmd.rsi_go = 1'b1;
        state_nxt  = ST_RSI_WAIT;
      end
      ST_RSI_WAIT: begin
        if (!sts.div_busy) begin
          cmd.rsi_store = 1'b1;
          state_nxt     = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // output register occupancy
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- rtl/core/rsi_checker.sv -----
module rsi_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [rsi_pkg::RSI_W-1:0] rsi_value,
  input logic                      rsi_valid
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // result never exceeds 100 percent
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> rsi_value <= rsi_pkg::RSI_SCALE)
    else $error("rsi_value above full scale");

  // warm-up results carry a zero value
  a_warm_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !rsi_valid |-> rsi_value == '0)
    else $error("nonzero value on an undefined result");

  // one transaction in flight at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second price taken while busy");

endmodule

bind relative_strength_index rsi_checker u_rsi_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .rsi_value (out_chan.rsi_value),
  .rsi_valid (out_chan.rsi_valid)
);
